@@ rtl/assert_macros.svh @@
// Assertion macros shared by the upsampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/wsu_pkg.sv @@
// Types, constants and coefficient table of the windowed-sinc upsampler.
`timescale 1ns / 1ps
package wsu_pkg;

  localparam int MAX_FACTOR   = 6;
  localparam int HALF_SPAN    = 4;
  localparam int MIN_LENGTH   = 10;
  localparam int NUM_CELLS    = MIN_LENGTH;
  localparam int RESET_FACTOR = 4;
  localparam int FRAC_BITS    = 14;

  localparam int SMP_W     = 16;
  localparam int OUT_W     = 18;
  localparam int COEF_W    = 16;
  localparam int ACC_W     = SMP_W + COEF_W + 2;
  localparam int F_W       = 3;
  localparam int A_W       = 8;
  localparam int K_W       = A_W - 1;
  localparam int LEAD_W    = $clog2(MIN_LENGTH);
  localparam int SEEN_W    = $clog2(MIN_LENGTH + 1);
  localparam int CNT_W     = $clog2(NUM_CELLS);
  localparam int TAB_COLS  = HALF_SPAN * MAX_FACTOR + 1;
  localparam int TAB_IDX_W = $clog2(TAB_COLS);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    last_in;
  } wsu_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    last_out;
    logic                    too_short;
  } wsu_out_t;

  // Job travelling down the cell chain: running tap offset and partial sum.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    err;
    logic [F_W-1:0]          f;
    logic signed [A_W-1:0]   a;
    logic signed [ACC_W-1:0] acc;
  } wsu_tag_t;

  // Window control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } wsu_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } wsu_state_t;

  localparam logic signed [COEF_W-1:0] CZ = '0;

  // Row f-1 holds the Q2.14 kernel sampled at k/f, k = 0..4f, zero beyond.
  localparam logic signed [COEF_W-1:0] COEF_TAB [MAX_FACTOR][TAB_COLS] = '{
    '{16'sd16384, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ,
      CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ},
    '{16'sd16384, 16'sd9960, CZ, -16'sd2213, CZ, 16'sd398, CZ, 16'sd203, CZ,
      CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ},
    '{16'sd16384, 16'sd13276, 16'sd6238, CZ, -16'sd2389, -16'sd1529, CZ,
      16'sd509, 16'sd207, CZ, 16'sd133, 16'sd206, CZ,
      CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ},
    '{16'sd16384, 16'sd14583, 16'sd9960, 16'sd4427, CZ, -16'sd2177,
      -16'sd2213, -16'sd1111, CZ, 16'sd492, 16'sd398, 16'sd121, CZ,
      16'sd86, 16'sd203, 16'sd177, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ},
    '{16'sd16384, 16'sd15215, 16'sd12040, 16'sd7733, 16'sd3399, CZ,
      -16'sd1933, -16'sd2403, -16'sd1840, -16'sd859, CZ, 16'sd449,
      16'sd483, 16'sd285, 16'sd78, CZ, 16'sd59, 16'sd167, 16'sd215,
      16'sd151, CZ, CZ, CZ, CZ, CZ},
    '{16'sd16384, 16'sd15566, 16'sd13276, 16'sd9960, 16'sd6238, 16'sd2747,
      CZ, -16'sd1719, -16'sd2389, -16'sd2213, -16'sd1529, -16'sd696, CZ,
      16'sd406, 16'sd509, 16'sd398, 16'sd207, 16'sd54, CZ, 16'sd43,
      16'sd133, 16'sd203, 16'sd206, 16'sd130, CZ}
  };

  function automatic logic signed [COEF_W-1:0] wsu_coef(
    input logic [F_W-1:0] f,
    input logic [K_W-1:0] k
  );
    logic signed [COEF_W-1:0] c;
    c = CZ;
    if ((f != '0) && (f <= F_W'(MAX_FACTOR)) && (k < K_W'(TAB_COLS))) begin
      c = COEF_TAB[f - 1'b1][k[TAB_IDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

@@ rtl/wsu_cell.sv @@
// One window cell: holds a sample and adds its tap to the passing partial sum.
`timescale 1ns / 1ps
module wsu_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  wsu_pkg::wsu_ctrl_t                ctrl,
  input  logic signed [wsu_pkg::SMP_W-1:0]  sample_prev,
  output logic signed [wsu_pkg::SMP_W-1:0]  sample,
  input  wsu_pkg::wsu_tag_t                 tag_prev,
  output wsu_pkg::wsu_tag_t                 tag
);
  import wsu_pkg::*;

  logic signed [A_W-1:0]          abs_a;
  logic signed [COEF_W-1:0]       coef;
  logic signed [SMP_W+COEF_W-1:0] prod;
  wsu_tag_t                       tag_next;

  always_comb begin
    abs_a    = tag_prev.a[A_W-1] ? -tag_prev.a : tag_prev.a;
    coef     = wsu_coef(tag_prev.f, abs_a[K_W-1:0]);
    prod     = sample * coef;
    tag_next = tag_prev;
    // offset to the next cell grows by one input spacing
    tag_next.a   = tag_prev.a + A_W'(tag_prev.f);
    tag_next.acc = tag_prev.acc + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctrl.clear) begin
      sample <= '0;
    end else if (ctrl.shift) begin
      sample <= sample_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag <= tag_next;
    end
  end

endmodule

@@ rtl/wsu_seq.sv @@
// Sequencer: plans the blocks for each sample and issues one job per output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsu_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   smp_valid,
  input  logic                   last_in,
  input  logic [wsu_pkg::F_W-1:0] factor,
  output logic                   smp_stall,
  output wsu_pkg::wsu_ctrl_t     ctrl,
  output wsu_pkg::wsu_tag_t      job
);
  import wsu_pkg::*;

  wsu_state_t              state;
  wsu_state_t              state_next;
  logic [SEEN_W-1:0]       seen;
  logic [SEEN_W-1:0]       seen_inc;
  logic                    flag;
  logic [LEAD_W-1:0]       lead;
  logic [LEAD_W-1:0]       lead_end;
  logic [F_W-1:0]          phase;
  logic [F_W-1:0]          fct;
  logic                    last_q;
  logic                    err_q;
  logic [CNT_W-1:0]        cnt;
  logic                    accept;
  logic                    has_jobs;
  logic                    final_job;
  logic                    drain_done;
  logic [LEAD_W+F_W-1:0]   lead_off;
  wsu_tag_t                job_next;

  always_comb begin
    accept     = smp_valid && (state == ST_IDLE);
    seen_inc   = (seen < SEEN_W'(MIN_LENGTH)) ? seen + 1'b1 : seen;
    has_jobs   = flag || (seen_inc == SEEN_W'(MIN_LENGTH)) || last_in;
    final_job  = err_q || ((phase == fct - 1'b1) && (lead == lead_end));
    drain_done = (cnt == CNT_W'(NUM_CELLS - 1));
    lead_off   = {{F_W{1'b0}}, lead} * {{LEAD_W{1'b0}}, fct};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && has_jobs) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (en && final_job) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (en && drain_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    smp_stall      = (state != ST_IDLE);
    ctrl.shift     = accept;
    ctrl.clear     = (state == ST_DRAIN) && en && drain_done && last_q;
    job_next       = '0;
    job_next.valid = (state == ST_ISSUE);
    job_next.last  = final_job && last_q;
    job_next.err   = err_q;
    job_next.f     = fct;
    job_next.a     = A_W'(phase) - A_W'(lead_off);
    job_next.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seen      <= '0;
      flag      <= 1'b0;
      cnt       <= '0;
      job.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        seen     <= seen_inc;
        if (seen_inc == SEEN_W'(MIN_LENGTH)) flag <= 1'b1;
        lead     <= flag ? LEAD_W'(HALF_SPAN) : LEAD_W'(MIN_LENGTH - 1);
        lead_end <= last_in ? '0 : LEAD_W'(HALF_SPAN);
        phase    <= '0;
        fct      <= factor;
        last_q   <= last_in;
        err_q    <= !flag && (seen_inc != SEEN_W'(MIN_LENGTH)) && last_in;
      end
      if ((state == ST_ISSUE) && en) begin
        if (phase == fct - 1'b1) begin
          phase <= '0;
          lead  <= lead - 1'b1;
        end else begin
          phase <= phase + 1'b1;
        end
      end
      if (state == ST_DRAIN) begin
        if (en) cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (en) job <= job_next;
      if (ctrl.clear) begin
        seen <= '0;
        flag <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_last_issues, accept && last_in, state == ST_ISSUE)
  `ASSERT_IMPL(a_idle_no_job, state == ST_IDLE, !job.valid)

endmodule

@@ rtl/windowed_sinc_upsampler.sv @@
// Top level of the windowed-sinc integer-factor upsampler.
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+----------------------
//  smp     | smp_valid, smp_stall, smp        | in        | smp_valid & !smp_stall
//  res     | res_valid, res_stall, res        | out       | res_valid & !res_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in        | cfg_valid & cfg_ready
//
// A sample that completes N outputs (N = factor * blocks) takes N + 11 cycles:
// the transfer cycle, N issue cycles, then ten cycles for the last job to walk
// the ten-cell chain, whose window must stay still until that job leaves cell nine.
// In a running sequence N = factor; a sample that completes nothing never stalls the input.
// rst is synchronous: the window clears, the factor returns to 4.
// A stall on res freezes the chain and the issue and drain counts.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_sinc_upsampler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    smp_valid,
  output logic                    smp_stall,
  input  wsu_pkg::wsu_in_t        smp,
  output logic                    res_valid,
  input  logic                    res_stall,
  output wsu_pkg::wsu_out_t       res,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [wsu_pkg::F_W-1:0] cfg_data
);
  import wsu_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic [F_W-1:0]            factor_reg;
  logic [F_W-1:0]            factor;
  logic                      en;
  wsu_ctrl_t                 ctrl;
  wsu_tag_t                  tag  [NUM_CELLS+1];
  logic signed [SMP_W-1:0]   samp [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]      chain_vld;
  logic signed [ACC_W-1:0]   shifted;
  wsu_out_t                  res_next;

  // Register write: always ready, the factor is sampled per input sample.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg <= F_W'(RESET_FACTOR);
    end else if (cfg_valid && cfg_ready) begin
      factor_reg <= cfg_data;
    end
  end

  // Clamp the factor into 1..MAX_FACTOR.
  always_comb begin
    if (factor_reg == '0) begin
      factor = F_W'(1);
    end else if (factor_reg > F_W'(MAX_FACTOR)) begin
      factor = F_W'(MAX_FACTOR);
    end else begin
      factor = factor_reg;
    end
  end

  // Advance the chain whenever the output register can take a new value.
  assign en = !res_valid || !res_stall;

  wsu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .smp_valid (smp_valid),
    .last_in   (smp.last_in),
    .factor    (factor),
    .smp_stall (smp_stall),
    .ctrl      (ctrl),
    .job       (tag[0])
  );

  assign samp[0] = smp.sample_in;

  // Cell j holds the sample j places before the newest one.
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    wsu_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .ctrl        (ctrl),
      .sample_prev (samp[j]),
      .sample      (samp[j+1]),
      .tag_prev    (tag[j]),
      .tag         (tag[j+1])
    );
    assign chain_vld[j] = tag[j].valid;
  end

  // Drop the fraction bits (floor), saturate to the output range; a too-short job gives zero.
  always_comb begin
    shifted  = tag[NUM_CELLS].acc >>> FRAC_BITS;
    res_next = '0;
    if (tag[NUM_CELLS].err) begin
      res_next.sample_out = '0;
      res_next.too_short  = 1'b1;
      res_next.last_out   = 1'b1;
    end else begin
      if (shifted > SAT_HI) begin
        res_next.sample_out = SAT_HI[OUT_W-1:0];
      end else if (shifted < SAT_LO) begin
        res_next.sample_out = SAT_LO[OUT_W-1:0];
      end else begin
        res_next.sample_out = shifted[OUT_W-1:0];
      end
      res_next.last_out  = tag[NUM_CELLS].last;
      res_next.too_short = 1'b0;
    end
  end

  // Output register: holds a result across res_stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= tag[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  `ASSERT_IMPL(a_short_flagged, res_valid && res.too_short, res.last_out && (res.sample_out == '0))
  `ASSERT_IMPL(a_idle_chain_empty, !smp_stall, chain_vld == '0)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the windowed-sinc integer-factor upsampler.
`timescale 1ns / 1ps
module tb_top;
  import wsu_pkg::*;

  localparam int WINDOW_LEN    = 10;
  localparam int SPAN          = 4;
  localparam int TOP_FACTOR    = 6;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLDOFF_LEN   = 300;

  // Q2.14 kernel, rows for factor 1..6 packed end to end. Row f holds
  // k = 0..4f and starts at (f-1)*(2f+1).
  localparam int KERNEL_Q14 [0:89] = '{
    16384, 0, 0, 0, 0,
    16384, 9960, 0, -2213, 0, 398, 0, 203, 0,
    16384, 13276, 6238, 0, -2389, -1529, 0, 509, 207, 0, 133, 206, 0,
    16384, 14583, 9960, 4427, 0, -2177, -2213, -1111, 0, 492, 398, 121, 0,
    86, 203, 177, 0,
    16384, 15215, 12040, 7733, 3399, 0, -1933, -2403, -1840, -859, 0, 449,
    483, 285, 78, 0, 59, 167, 215, 151, 0,
    16384, 15566, 13276, 9960, 6238, 2747, 0, -1719, -2389, -2213, -1529,
    -696, 0, 406, 509, 398, 207, 54, 0, 43, 133, 203, 206, 130, 0
  };

  // Full-scale pattern used to fill the window in the factor-limits test.
  localparam logic signed [15:0] EDGE_PAT [WINDOW_LEN] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh4000
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 smp_valid = 1'b0;
  logic                 smp_stall;
  wsu_in_t              smp       = '0;
  logic                 res_valid;
  logic                 res_stall;
  wsu_out_t             res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [F_W-1:0]       cfg_data  = '0;

  // Receiver back-pressure: random stalls plus a long hold-off on request.
  logic stall_rnd = 1'b0;
  logic holdoff   = 1'b0;
  assign res_stall = stall_rnd | holdoff;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int cycle_count   = 0;

  // Shadow of the upsampler: sample history (newest first), fill count,
  // whether the first blocks have gone out, and the factor register.
  logic signed [15:0] hist [WINDOW_LEN];
  int                 hist_count;
  bit                 blocks_started;
  logic [F_W-1:0]     factor_reg;

  // Upsampled outputs still owed by the block, oldest first.
  wsu_out_t upsampled_q [$];

  windowed_sinc_upsampler dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs outstanding",
               cycle_count, upsampled_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_rnd <= !rst && ($urandom_range(99) < rcv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic int kernel_at(int f, int k);
    if (k > SPAN * f) return 0;
    return KERNEL_Q14[(f - 1) * (2 * f + 1) + k];
  endfunction

  // Clamp the register into the supported range: 0 acts as 1, 7 as 6.
  function automatic int live_factor();
    int f;
    f = int'(factor_reg);
    if (f < 1) f = 1;
    if (f > TOP_FACTOR) f = TOP_FACTOR;
    return f;
  endfunction

  // Append one owed output behind the ones already queued.
  function automatic void owe_output(wsu_out_t r);
    upsampled_q = {upsampled_q, r};
  endfunction

  // Queue the f outputs of the block centred 'lead' samples behind the newest.
  function automatic void emit_block(int lead, int f);
    longint   acc;
    longint   y;
    wsu_out_t r;
    int       rel;
    int       k;
    for (int p = 0; p < f; p++) begin
      acc = 0;
      for (int d = -SPAN; d < SPAN; d++) begin
        rel = lead + d;
        k   = d * f + p;
        if (k < 0) k = -k;
        if (rel >= 0 && rel < WINDOW_LEN)
          acc += longint'(hist[rel]) * longint'(kernel_at(f, k));
      end
      // Arithmetic shift floors for either sign.
      y = acc >>> 14;
      if (y > 131071) y = 131071;
      if (y < -131072) y = -131072;
      r.sample_out = y[17:0];
      r.last_out   = 1'b0;
      r.too_short  = 1'b0;
      owe_output(r);
    end
  endfunction

  function automatic void flush_blocks(int f);
    for (int lead = SPAN - 1; lead >= 0; lead--) emit_block(lead, f);
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < WINDOW_LEN; i++) hist[i] = '0;
    hist_count     = 0;
    blocks_started = 1'b0;
  endfunction

  // Advance the shadow by one accepted sample and queue what it completes.
  function automatic void interpolate_sample(wsu_in_t it);
    int       f;
    wsu_out_t r;
    f = live_factor();
    for (int i = WINDOW_LEN - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = it.sample_in;
    if (hist_count < WINDOW_LEN) hist_count++;
    if (!blocks_started) begin
      if (hist_count >= WINDOW_LEN) begin
        for (int lead = WINDOW_LEN - 1; lead >= SPAN; lead--) emit_block(lead, f);
        blocks_started = 1'b1;
        if (it.last_in) flush_blocks(f);
      end else if (it.last_in) begin
        r.sample_out = '0;
        r.last_out   = 1'b1;
        r.too_short  = 1'b1;
        owe_output(r);
      end
    end else begin
      emit_block(SPAN, f);
      if (it.last_in) flush_blocks(f);
    end
    // Every closing sample yields at least one output: tag the final one.
    if (it.last_in) begin
      upsampled_q[upsampled_q.size() - 1].last_out = 1'b1;
      clear_history();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic void note_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin
    wsu_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (upsampled_q.size() == 0) begin
        note_mismatch("unexpected output sample_out", 0, int'(res.sample_out));
      end else begin
        want = upsampled_q.pop_front();
        if (want.sample_out !== res.sample_out)
          note_mismatch("sample_out", int'(want.sample_out), int'(res.sample_out));
        if (want.last_out !== res.last_out)
          note_mismatch("last_out", int'(want.last_out), int'(res.last_out));
        if (want.too_short !== res.too_short)
          note_mismatch("too_short", int'(want.too_short), int'(res.too_short));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offer one sample, idling first at the sender's rate, and hold it until
  // the transfer completes. Valid is left high for a back-to-back follower.
  task automatic send_sample(logic signed [15:0] v, logic is_last);
    wsu_in_t it;
    it.sample_in = v;
    it.last_in   = is_last;
    while ($urandom_range(99) < snd_idle_pct) begin
      smp_valid <= 1'b0;
      @(posedge clk);
    end
    smp       <= it;
    smp_valid <= 1'b1;
    do @(posedge clk); while (smp_stall);
    interpolate_sample(it);
    samples_sent++;
  endtask

  // Drop valid, wait for every owed output, then let the pipe empty out.
  task automatic settle();
    smp_valid <= 1'b0;
    while (upsampled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_factor(logic [F_W-1:0] v);
    settle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    factor_reg  = v;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(31)) - 16'sd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // One sequence of random content; optionally retune the factor while the
  // block is quiet somewhere after the first blocks have gone out.
  task automatic run_sequence(int len, bit retune);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(), i == len - 1);
      if (retune && i >= WINDOW_LEN - 1 && i < len - 1 && $urandom_range(15) == 0)
        write_factor(F_W'($urandom_range(7)));
    end
  endtask

  // Hold the receiver off for a long stretch while samples keep coming, so
  // the chain fills and the input stalls. Runs at the reset factor.
  task automatic test_backpressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    fork
      begin
        holdoff <= 1'b1;
        repeat (HOLDOFF_LEN) @(posedge clk);
        holdoff <= 1'b0;
      end
    join_none
    run_sequence(30, 1'b0);
    settle();
  endtask

  // A lone closing sample, then a sequence one short of the minimum.
  task automatic test_short_sequences();
    send_sample(16'sh8000, 1'b1);
    for (int i = 0; i < WINDOW_LEN - 1; i++)
      send_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == WINDOW_LEN - 2);
    settle();
  endtask

  // Above-range factor for the first blocks, then factor 0 for the flush,
  // changed mid-sequence while the block is quiet.
  task automatic test_factor_limits();
    write_factor(F_W'(7));
    for (int i = 0; i < WINDOW_LEN; i++) send_sample(EDGE_PAT[i], 1'b0);
    write_factor(F_W'(0));
    send_sample(16'shffff, 1'b1);
    settle();
  endtask

  task automatic test_random_phase(int snd, int rcv, int quota);
    int start;
    int len;
    int r;
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    start         = samples_sent;
    while (samples_sent - start < quota) begin
      if ($urandom_range(1) == 1) write_factor(F_W'($urandom_range(7)));
      r = $urandom_range(99);
      if (r < 12)      len = $urandom_range(9, 1);
      else if (r < 22) len = WINDOW_LEN;
      else if (r < 90) len = $urandom_range(30, 11);
      else             len = $urandom_range(60, 31);
      run_sequence(len, 1'b1);
    end
  endtask

  initial begin
    int leftover;
    clear_history();
    factor_reg = F_W'(RESET_FACTOR);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_backpressure();
    test_short_sequences();
    test_factor_limits();
    test_random_phase(0, 0, 95);
    test_random_phase(62, 0, 95);
    test_random_phase(0, 62, 95);
    test_random_phase(14, 14, 95);

    settle();
    leftover = upsampled_q.size();
    if (mismatches == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
